// ===== hdl/sdl_pkg.sv =====
// Package with the shared types, constants and helpers of the SDI line deframer.
package sdl_pkg;

  localparam int unsigned ActiveWidthDef = 720;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] RegTotalLines  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegActiveLines = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLineWidth   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFirstStart  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSecondStart = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTopFirst    = 3'd5;

  localparam logic [9:0]  TotalLinesRst  = 10'd625;
  localparam logic [9:0]  ActiveLinesRst = 10'd576;
  localparam logic [10:0] LineWidthRst   = 11'd864;
  localparam logic [9:0]  FirstStartRst  = 10'd23;
  localparam logic [9:0]  SecondStartRst = 10'd336;
  localparam logic        TopFirstRst    = 1'b1;

  // Upper 25 bits of a timing word: 0xFF, 0x00, 0x00 and the fixed one bit of XY.
  localparam logic [24:0] SyncTag = {8'hff, 16'h0000, 1'b1};

  localparam int unsigned FBit = 6;
  localparam int unsigned HBit = 4;

  typedef struct packed {
    logic [9:0]  total_lines;
    logic [9:0]  picture_lines;
    logic [10:0] line_width;
    logic [9:0]  first_field_start;
    logic [9:0]  second_field_start;
    logic        top_first;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] pixel_word;
    logic        pixel_valid;
    logic [9:0]  frame_row;
    logic [8:0]  group_column;
    logic        frame_end;
  } res_t;

  function automatic logic [31:0] unpack_group(input logic [39:0] g);
    unpack_group = {g[9:2], g[19:12], g[29:22], g[39:32]};
  endfunction

endpackage

// ===== hdl/sdl_cfg.sv =====
// Configuration register file of the SDI line deframer.
module sdl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [sdl_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [sdl_pkg::CfgDataW-1:0] wr_data_i,
  output sdl_pkg::cfg_t               cfg_o
);
  import sdl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        RegTotalLines:  cfg_d.total_lines        = wr_data_i[9:0];
        RegActiveLines: cfg_d.picture_lines      = wr_data_i[9:0];
        RegLineWidth:   cfg_d.line_width         = wr_data_i[10:0];
        RegFirstStart:  cfg_d.first_field_start  = wr_data_i[9:0];
        RegSecondStart: cfg_d.second_field_start = wr_data_i[9:0];
        RegTopFirst:    cfg_d.top_first          = wr_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_lines        <= TotalLinesRst;
      cfg_q.picture_lines      <= ActiveLinesRst;
      cfg_q.line_width         <= LineWidthRst;
      cfg_q.first_field_start  <= FirstStartRst;
      cfg_q.second_field_start <= SecondStartRst;
      cfg_q.top_first          <= TopFirstRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/sdl_timing.sv =====
// Line and field timing tracker: lock state, counters and the result of one group.
module sdl_timing #(
  parameter int unsigned ACTIVE_WIDTH = sdl_pkg::ActiveWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [39:0]   group_i,
  input  logic          discont_i,
  input  sdl_pkg::cfg_t cfg_i,
  output sdl_pkg::res_t res_o
);
  import sdl_pkg::*;

  localparam logic [11:0] AwPlusTwo = 12'(ACTIVE_WIDTH + 2);
  localparam logic [11:0] AwFull    = 12'(ACTIVE_WIDTH);
  localparam logic [10:0] HalfAw    = 11'(ACTIVE_WIDTH / 2);

  logic       line_locked_q, line_locked_d;
  logic       field_locked_q, field_locked_d;
  logic [9:0] line_count_q, line_count_d;
  logic [9:0] group_pos_q, group_pos_d;
  logic       last_fbit_q, last_fbit_d;

  logic [31:0] word;
  logic        is_sync, fbit, hbit;
  logic        line_lock0, field_lock0, proceed;
  logic [9:0]  lc0, lc1, lc_inc, pos;
  logic [10:0] astart, astart_m1, col, pos_p1;
  logic [11:0] lw_diff;
  logic        at_sync, active, line_end, fe;
  logic [8:0]  half_lines;
  logic [11:0] diff1, diff2;
  logic        hit1, hit2;

  always_comb begin
    word    = unpack_group(group_i);
    is_sync = (word[31:7] == SyncTag);
    fbit    = word[FBit];
    hbit    = word[HBit];

    line_lock0  = line_locked_q & ~discont_i;
    field_lock0 = field_locked_q & ~discont_i;
    proceed     = line_lock0 | (is_sync & hbit);

    lc0 = line_lock0 ? line_count_q : '0;
    pos = line_lock0 ? group_pos_q : '0;

    lw_diff = {1'b0, cfg_i.line_width} - AwFull;
    if ({1'b0, cfg_i.line_width} >= AwPlusTwo) begin
      astart = lw_diff[11:1];
    end else begin
      astart = 11'd1;
    end
    astart_m1 = astart - 11'd1;

    at_sync = ({1'b0, pos} == astart_m1);

    field_locked_d = field_lock0;
    last_fbit_d    = last_fbit_q;
    lc1            = lc0;
    if (proceed && at_sync) begin
      if (!field_lock0) begin
        field_locked_d = is_sync & ~fbit & last_fbit_q;
        lc1            = '0;
      end
      last_fbit_d = fbit;
    end

    col    = {1'b0, pos} - astart;
    active = ({1'b0, pos} >= astart) && (col < HalfAw);

    half_lines = cfg_i.picture_lines[9:1];
    diff1 = {2'b00, lc1} - {2'b00, cfg_i.first_field_start} + 12'd1;
    diff2 = {2'b00, lc1} - {2'b00, cfg_i.second_field_start} + 12'd1;
    hit1  = ~diff1[11] && (diff1[10:0] < {2'b00, half_lines});
    hit2  = ~diff2[11] && (diff2[10:0] < {2'b00, half_lines});

    pos_p1   = {1'b0, pos} + 11'd1;
    line_end = (pos_p1 >= {1'b0, cfg_i.line_width[10:1]});
    lc_inc   = lc1 + 10'd1;
    fe       = line_end && (lc_inc == cfg_i.total_lines);

    if (line_end) begin
      group_pos_d  = '0;
      line_count_d = fe ? '0 : lc_inc;
    end else begin
      group_pos_d  = pos_p1[9:0];
      line_count_d = lc1;
    end

    line_locked_d = proceed;

    res_o = '0;
    if (proceed && active && (hit1 || hit2)) begin
      res_o.pixel_valid  = 1'b1;
      res_o.pixel_word   = word;
      res_o.group_column = col[8:0];
      if (hit1) begin
        res_o.frame_row = {diff1[8:0], ~cfg_i.top_first};
      end else begin
        res_o.frame_row = {diff2[8:0], cfg_i.top_first};
      end
    end
    res_o.frame_end = proceed & fe;
    res_o.emit      = res_o.pixel_valid | res_o.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_locked_q  <= 1'b0;
      field_locked_q <= 1'b0;
      line_count_q   <= '0;
      group_pos_q    <= '0;
      last_fbit_q    <= 1'b0;
    end else if (step_i) begin
      line_locked_q  <= line_locked_d;
      field_locked_q <= field_locked_d;
      if (proceed) begin
        line_count_q <= line_count_d;
        group_pos_q  <= group_pos_d;
        last_fbit_q  <= last_fbit_d;
      end
    end
  end

endmodule

// ===== hdl/sdl_line_deframer_top.sv =====
// An accepted word waits in the input stage; its emitted result is then registered.
// Throughput: one 40-bit group per cycle, unless output stalls, in single-pass logic.
// The input stage takes a new word whenever it is empty or passes its word on that cycle.
// Reset is asynchronous and active low; it clears the locks, counters and stage flags
// and loads the configuration registers with their default values.
module sdi_line_deframer_top #(
  parameter int unsigned ACTIVE_WIDTH = sdl_pkg::ActiveWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,  // packed_group
  input  logic [0:0]                  s_axis_tuser,  // discont
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,  // pixel_word, frame_row, group_column
  output logic [0:0]                  m_axis_tuser,  // pixel_valid
  output logic                        m_axis_tlast,  // frame_end
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sdl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdl_pkg::CfgDataW-1:0] cfg_data_i
);
  import sdl_pkg::*;

  cfg_t cfg;
  res_t res;

  logic        in_valid_q, in_valid_d;
  logic [39:0] in_group_q;
  logic        in_discont_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_q;
  logic        advance, in_take;

  assign cfg_ready_o = 1'b1;

  sdl_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  sdl_timing #(
    .ACTIVE_WIDTH (ACTIVE_WIDTH)
  ) u_timing (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .group_i   (in_group_q),
    .discont_i (in_discont_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_group_q   <= s_axis_tdata;
      in_discont_q <= s_axis_tuser[0];
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.group_column, out_q.frame_row, out_q.pixel_word};
  assign m_axis_tuser  = out_q.pixel_valid;
  assign m_axis_tlast  = out_q.frame_end;

`ifndef SYNTHESIS
  a_only_active_or_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.pixel_valid || out_q.frame_end))
    else $error("result word is neither active video nor frame end");

  a_blank_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pixel_valid) |-> (out_q.pixel_word == '0 &&
      out_q.frame_row == '0 && out_q.group_column == '0))
    else $error("non-active result carries payload");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.pixel_valid) |->
      ({2'b00, out_q.group_column} < 11'(ACTIVE_WIDTH / 2)))
    else $error("group column beyond active line");

  a_out_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(advance))
    else $error("result appeared without a processed word");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input stage refuses a word");
`endif

endmodule
